// File: rtl/tfc_pkg.sv
// Shared types and constants for the transparency fragment compositor.
// Used by tfc_front, tfc_back and transparency_fragment_compositor.
package tfc_pkg;

	localparam logic [12:0] OPA_ONE      = 13'd4096;
	localparam logic [12:0] OPAQUE_LIMIT = 13'd4095;
	localparam logic [15:0] COLOR_MAX    = 16'hFFFF;
	localparam logic [23:0] VEIL_SUM_MAX = 24'hFFFFFF;
	localparam logic [19:0] VEIL_W_MAX   = 20'hFFFFF;
	localparam logic [19:0] OVER_SUM_MAX = 20'hFFFFF;

	typedef enum logic [2:0] {
		CFG_TRANSPARENCY_ON = 3'd0,
		CFG_MAX_LAYERS      = 3'd1,
		CFG_TRANSP_BACKDROP = 3'd2,
		CFG_BACKDROP_RED    = 3'd3,
		CFG_BACKDROP_GREEN  = 3'd4,
		CFG_BACKDROP_BLUE   = 3'd5,
		CFG_VEIL_MASK       = 3'd6,
		CFG_UNUSED          = 3'd7
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_MISS  = 2'd0,
		KIND_FLOOR = 2'd1,
		KIND_VEIL  = 2'd2,
		KIND_OVER  = 2'd3
	} kind_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] frag_red;
		logic [15:0] frag_green;
		logic [15:0] frag_blue;
		logic [12:0] frag_opacity;
		logic [5:0]  frag_group;
		logic [31:0] frag_depth;
	} frag_t;

	typedef struct packed {
		logic [15:0] pix_red;
		logic [15:0] pix_green;
		logic [15:0] pix_blue;
		logic [12:0] pix_alpha;
		logic [31:0] pix_depth;
		logic        layer_capped;
	} pix_t;

	typedef struct packed {
		logic        transparency_on;
		logic [5:0]  max_layers;
		logic        transparent_backdrop;
		logic [15:0] backdrop_red;
		logic [15:0] backdrop_green;
		logic [15:0] backdrop_blue;
		logic [63:0] veil_mask;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		frag_t frag;
	} qitem_t;

	// Queue handshake between the front and the back.
	typedef struct packed {
		logic   valid;
		qitem_t item;
	} qhead_t;

endpackage

// File: rtl/tfc_front.sv
// Front end: accepts fragment items, classifies them and queues them.
// Depends on tfc_pkg.
module tfc_front import tfc_pkg::*; #(
	parameter int NUM_GROUPS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   frag_valid,
	output logic   frag_stall,
	input  frag_t  frag,
	output qhead_t head,
	input  logic   pop
);

	localparam int DEPTH = 2;

	qitem_t     mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	qitem_t     cls;
	logic       push;

	always_comb begin
		cls.frag = frag;
		if (frag.cmd) begin
			cls.kind = KIND_MISS;
		end else if (!cfg.transparency_on || frag.frag_opacity >= OPAQUE_LIMIT) begin
			cls.kind = KIND_FLOOR;
		end else if ((32'(frag.frag_group) < NUM_GROUPS) && cfg.veil_mask[frag.frag_group]) begin
			cls.kind = KIND_VEIL;
		end else begin
			cls.kind = KIND_OVER;
		end
	end

	assign frag_stall = (count_q == 2'(DEPTH));
	assign push       = frag_valid && !frag_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: rtl/tfc_back.sv
// Back end: sequencer that blends queued items and resolves finished pixels.
// Depends on tfc_pkg.
module tfc_back import tfc_pkg::*; #(
	parameter int NUM_GROUPS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  qhead_t head,
	output logic   pop,
	output logic   pix_valid,
	input  logic   pix_stall,
	output pix_t   pix
);

	localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_HIT_A, S_HIT_B, S_HIT_C, S_FIN_A, S_FIN_B, S_FIN_C
	} state_t;

	state_t state_q;
	qitem_t cur_q;

	logic [23:0] vs_q [3];
	logic [19:0] os_q [3];
	logic [19:0] vw_q;
	logic [12:0] oc_q;
	logic [31:0] fd_q;
	logic [NUM_GROUPS-1:0] seen_q;
	logic [6:0]  lc_q;

	logic [15:0] base_q [3];
	logic        full_q;
	logic        capped_q;

	logic [12:0] af_q;
	logic [12:0] w_q;
	logic [16:0] vadd_q [3];
	logic [12:0] floor_w_q;
	logic [12:0] cov_q;
	logic [12:0] vwt_q;
	logic [20:0] eff_q [3];
	logic [12:0] acov_q;

	pix_t pix_q;
	logic pix_valid_q;

	logic [15:0] fcol [3];
	logic        out_free;
	logic [12:0] af_c;
	logic [GW-1:0] gidx;

	assign fcol[0] = cur_q.frag.frag_red;
	assign fcol[1] = cur_q.frag.frag_green;
	assign fcol[2] = cur_q.frag.frag_blue;
	assign af_c    = (oc_q > OPA_ONE) ? OPA_ONE : oc_q;
	assign gidx    = cur_q.frag.frag_group[GW-1:0];
	assign out_free = !pix_valid_q || !pix_stall;
	assign pop      = (state_q == S_IDLE) && head.valid;
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [26:0] pw;
		logic [28:0] pv;
		logic [28:0] po;
		logic [24:0] sv;
		logic [20:0] sw;
		logic [20:0] so;
		logic [13:0] sc;
		logic [16:0] oadd;
		logic [6:0]  lc_n;
		logic [28:0] pf;
		logic [26:0] pa;
		logic [34:0] pc;
		logic [24:0] cs;
		logic [20:0] asum;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pix_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				vs_q[i] <= '0;
				os_q[i] <= '0;
			end
			vw_q   <= '0;
			oc_q   <= '0;
			fd_q   <= '0;
			seen_q <= '0;
			lc_q   <= '0;
		end else begin
			// The last resolve step loads a new pixel in the same cycle the old one leaves.
			if (pix_valid_q && !pix_stall && state_q != S_FIN_C) begin
				pix_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						cur_q <= head.item;
						if (head.item.kind != KIND_MISS && lc_q == 7'd0) begin
							fd_q <= head.item.frag.frag_depth;
						end
						capped_q <= 1'b0;
						unique case (head.item.kind)
							KIND_MISS: begin
								base_q[0] <= cfg.backdrop_red;
								base_q[1] <= cfg.backdrop_green;
								base_q[2] <= cfg.backdrop_blue;
								full_q    <= !cfg.transparent_backdrop;
								state_q   <= S_FIN_A;
							end
							KIND_FLOOR: begin
								base_q[0] <= head.item.frag.frag_red;
								base_q[1] <= head.item.frag.frag_green;
								base_q[2] <= head.item.frag.frag_blue;
								full_q    <= 1'b1;
								state_q   <= S_FIN_A;
							end
							KIND_VEIL, KIND_OVER: begin
								state_q <= S_HIT_A;
							end
						endcase
					end
				end
				S_HIT_A: begin
					af_q <= af_c;
					pw = 27'((OPA_ONE - af_c) * cur_q.frag.frag_opacity) + 27'd2048;
					w_q <= pw[24:12];
					for (int i = 0; i < 3; i++) begin
						pv = 29'(cur_q.frag.frag_opacity * fcol[i]) + 29'd2048;
						vadd_q[i] <= {1'b0, pv[27:12]};
					end
					state_q <= S_HIT_B;
				end
				S_HIT_B: begin
					if (cur_q.kind == KIND_VEIL) begin
						if (!seen_q[gidx]) begin
							seen_q[gidx] <= 1'b1;
							for (int i = 0; i < 3; i++) begin
								sv = {1'b0, vs_q[i]} + 25'(vadd_q[i]);
								vs_q[i] <= (sv > 25'(VEIL_SUM_MAX)) ? VEIL_SUM_MAX : sv[23:0];
							end
							sw = {1'b0, vw_q} + 21'(cur_q.frag.frag_opacity);
							vw_q <= (sw > 21'(VEIL_W_MAX)) ? VEIL_W_MAX : sw[19:0];
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							po = 29'(w_q * fcol[i]) + 29'd2048;
							oadd = {1'b0, po[27:12]};
							so = {1'b0, os_q[i]} + 21'(oadd);
							os_q[i] <= (so > 21'(OVER_SUM_MAX)) ? OVER_SUM_MAX : so[19:0];
						end
						sc = {1'b0, af_q} + {1'b0, w_q};
						oc_q <= (sc > 14'(OPA_ONE)) ? OPA_ONE : sc[12:0];
					end
					state_q <= S_HIT_C;
				end
				S_HIT_C: begin
					lc_n = lc_q + 7'd1;
					base_q[0] <= cfg.backdrop_red;
					base_q[1] <= cfg.backdrop_green;
					base_q[2] <= cfg.backdrop_blue;
					full_q    <= !cfg.transparent_backdrop;
					if (vw_q >= 20'(OPAQUE_LIMIT) || oc_q >= OPAQUE_LIMIT) begin
						capped_q <= 1'b0;
						state_q  <= S_FIN_A;
					end else if ({1'b0, lc_n} >= ({2'b0, cfg.max_layers} + 8'd1)) begin
						capped_q <= 1'b1;
						state_q  <= S_FIN_A;
					end else begin
						lc_q    <= lc_n;
						state_q <= S_IDLE;
					end
				end
				S_FIN_A: begin
					floor_w_q <= full_q ? (OPA_ONE - af_c) : 13'd0;
					cov_q     <= full_q ? OPA_ONE : af_c;
					vwt_q     <= (vw_q >= 20'(OPA_ONE)) ? 13'd0 : (OPA_ONE - vw_q[12:0]);
					state_q   <= S_FIN_B;
				end
				S_FIN_B: begin
					for (int i = 0; i < 3; i++) begin
						pf = 29'(floor_w_q * base_q[i]) + 29'd2048;
						eff_q[i] <= {1'b0, os_q[i]} + 21'(pf[27:12]);
					end
					pa = 27'(vwt_q * cov_q) + 27'd2048;
					acov_q  <= pa[24:12];
					state_q <= S_FIN_C;
				end
				S_FIN_C: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							pc = 35'(vwt_q * eff_q[i]) + 35'd2048;
							cs = {1'b0, vs_q[i]} + 25'(pc[34:12]);
							if (cs > 25'(COLOR_MAX)) begin
								cs = 25'(COLOR_MAX);
							end
							unique case (i)
								0: pix_q.pix_red   <= cs[15:0];
								1: pix_q.pix_green <= cs[15:0];
								default: pix_q.pix_blue <= cs[15:0];
							endcase
						end
						asum = {1'b0, vw_q} + 21'(acov_q);
						pix_q.pix_alpha    <= (asum > 21'(OPA_ONE)) ? OPA_ONE : asum[12:0];
						pix_q.pix_depth    <= fd_q;
						pix_q.layer_capped <= capped_q;
						pix_valid_q        <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							vs_q[i] <= '0;
							os_q[i] <= '0;
						end
						vw_q    <= '0;
						oc_q    <= '0;
						fd_q    <= '0;
						seen_q  <= '0;
						lc_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/transparency_fragment_compositor.sv
// Top level of the transparency fragment compositor: configuration registers,
// front end (tfc_front) and blending back end (tfc_back). Depends on tfc_pkg.
//
//   channel  direction  handshake                 payload
//   frag     in         frag_valid / frag_stall   frag_t
//   pix      out        pix_valid  / pix_stall    pix_t
//   cfg      in         cfg_we                    cfg_index, cfg_data
//
// A hit that continues the ray passes through the pop, two blend steps and the
// end-of-ray test in the back end; a hit that ends the ray goes on through the
// resolve steps S_FIN_A, S_FIN_B and S_FIN_C, and a miss or an opaque floor hit
// goes straight from the pop to them. The back end's blend sequencer takes one
// item at a time and waits in its last step while the output pixel is not taken.
// A two-item queue lets the front keep accepting while the back is busy.
// Reset clears all ray accumulators and loads the register defaults.
module transparency_fragment_compositor import tfc_pkg::*; #(
	parameter int NUM_GROUPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        frag_valid,
	output logic        frag_stall,
	input  frag_t       frag,
	output logic        pix_valid,
	input  logic        pix_stall,
	output pix_t        pix
);

	cfg_t   cfg_q;
	qhead_t head;
	logic   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transparency_on      <= 1'b1;
			cfg_q.max_layers           <= 6'd8;
			cfg_q.transparent_backdrop <= 1'b0;
			cfg_q.backdrop_red         <= '0;
			cfg_q.backdrop_green       <= '0;
			cfg_q.backdrop_blue        <= '0;
			cfg_q.veil_mask            <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TRANSPARENCY_ON: cfg_q.transparency_on      <= cfg_data[0];
				CFG_MAX_LAYERS:      cfg_q.max_layers           <= cfg_data[5:0];
				CFG_TRANSP_BACKDROP: cfg_q.transparent_backdrop <= cfg_data[0];
				CFG_BACKDROP_RED:    cfg_q.backdrop_red         <= cfg_data[15:0];
				CFG_BACKDROP_GREEN:  cfg_q.backdrop_green       <= cfg_data[15:0];
				CFG_BACKDROP_BLUE:   cfg_q.backdrop_blue        <= cfg_data[15:0];
				CFG_VEIL_MASK:       cfg_q.veil_mask            <= cfg_data;
				CFG_UNUSED:          cfg_q.veil_mask            <= cfg_q.veil_mask;
			endcase
		end
	end

	tfc_front #(.NUM_GROUPS(NUM_GROUPS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.frag_valid (frag_valid),
		.frag_stall (frag_stall),
		.frag       (frag),
		.head       (head),
		.pop        (pop)
	);

	tfc_back #(.NUM_GROUPS(NUM_GROUPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

`ifndef NO_ASSERTIONS
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("queue popped while empty");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		frag_stall |-> head.valid) else $error("queue full but no head item");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> (pix.pix_alpha <= OPA_ONE)) else $error("alpha out of range");
`endif

endmodule
